// ===== rtl/aarm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_pkg: shared types and constants for the axis-angle rotation matrix
// Word formats, internal widths, stage counts and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package aarm_pkg;

   localparam int ANGLE_FRAC_BITS = 13;
   localparam int OUT_FRAC_BITS   = 14;
   localparam int CORDIC_STAGES   = 16;

   localparam int FIELD_W = 16;
   localparam int FRAC_Q  = 30;

   // square root and normalizing divide
   localparam int SQ_W         = 2 * FIELD_W - 1;
   localparam int SUM_W        = SQ_W + 2;
   localparam int RAD_W        = 64;
   localparam int ISQRT_STAGES = RAD_W / 2;
   localparam int ROOT_W       = 32;
   localparam int REM_W        = ROOT_W;
   localparam int NORM_SHIFT   = 45;
   localparam int DIV_STAGES   = 32;
   localparam int DIV_PRESHIFT = NORM_SHIFT - DIV_STAGES;
   localparam int N_W          = 32;

   // angle and CORDIC
   localparam int Z_W       = 36;
   localparam int XY_W      = 34;
   localparam int CS_W      = 32;
   localparam int ANG_SHIFT = FRAC_Q - ANGLE_FRAC_BITS;

   // matrix assembly
   localparam int P_W       = 64;
   localparam int NN_W      = 34;
   localparam int OUT_SHIFT = 2 * FRAC_Q - OUT_FRAC_BITS;

   // stage bookkeeping
   localparam int FRONT_LAT    = 3;
   localparam int MATRIX_LAT   = 5;
   localparam int CORDIC_DELAY = ISQRT_STAGES + DIV_STAGES + 1 - CORDIC_STAGES;
   localparam int PIPE_DEPTH   = FRONT_LAT + ISQRT_STAGES + DIV_STAGES + 1 + MATRIX_LAT;

   localparam logic signed [Z_W-1:0] Z_PI      = Z_W'(64'sd3373259426);
   localparam logic signed [Z_W-1:0] Z_TWO_PI  = Z_W'(64'sd6746518852);
   localparam logic signed [Z_W-1:0] Z_HALF_PI = Z_W'(64'sd1686629713);
   localparam logic signed [XY_W-1:0] XY_INV_GAIN = XY_W'(64'sd652032874);

   localparam logic signed [NN_W-1:0] NN_ONE   = NN_W'(1) <<< FRAC_Q;
   localparam logic signed [P_W-1:0]  NN_HALF  = P_W'(1) <<< (FRAC_Q - 1);
   localparam logic signed [P_W-1:0]  OUT_HALF = P_W'(1) <<< (OUT_SHIFT - 1);
   localparam logic signed [P_W-1:0]  OUT_LIM  = P_W'(1) <<< OUT_FRAC_BITS;

   typedef logic signed [FIELD_W-1:0] field_type;
   localparam field_type ONE_FIELD = FIELD_W'(OUT_LIM);

   typedef struct packed {
      field_type angle;
      field_type axis_x;
      field_type axis_y;
      field_type axis_z;
   } req_type;

   typedef struct packed {
      field_type m00;
      field_type m01;
      field_type m02;
      field_type m10;
      field_type m11;
      field_type m12;
      field_type m20;
      field_type m21;
      field_type m22;
      logic      zero_axis;
   } rsp_type;

   // index 0 is x, 1 is y, 2 is z
   typedef field_type [2:0] axis_type;

   typedef struct packed {
      axis_type axis;
      logic     zero;
   } side_type;

   typedef logic signed [N_W-1:0] norm_type;
   typedef norm_type [2:0] nvec_type;

   typedef struct packed {
      logic signed [CS_W-1:0] c;
      logic signed [CS_W-1:0] s;
   } trig_type;

   // atan(2^-i) in Q30
   function automatic logic [30:0] atan_q30(input logic [4:0] idx);
      logic [30:0] val;
      case (idx)
         5'd0:    val = 31'd843314857;
         5'd1:    val = 31'd497837829;
         5'd2:    val = 31'd263043837;
         5'd3:    val = 31'd133525159;
         5'd4:    val = 31'd67021687;
         5'd5:    val = 31'd33543516;
         5'd6:    val = 31'd16775851;
         5'd7:    val = 31'd8388437;
         5'd8:    val = 31'd4194283;
         5'd9:    val = 31'd2097149;
         5'd10:   val = 31'd1048576;
         5'd11:   val = 31'd524288;
         5'd12:   val = 31'd262144;
         5'd13:   val = 31'd131072;
         5'd14:   val = 31'd65536;
         5'd15:   val = 31'd32768;
         5'd16:   val = 31'd16384;
         5'd17:   val = 31'd8192;
         5'd18:   val = 31'd4096;
         5'd19:   val = 31'd2048;
         5'd20:   val = 31'd1024;
         5'd21:   val = 31'd512;
         5'd22:   val = 31'd256;
         5'd23:   val = 31'd128;
         5'd24:   val = 31'd64;
         5'd25:   val = 31'd32;
         5'd26:   val = 31'd16;
         5'd27:   val = 31'd8;
         5'd28:   val = 31'd4;
         5'd29:   val = 31'd2;
         5'd30:   val = 31'd1;
         default: val = 31'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix: 3x3 rotation matrix from an angle and an axis
// Normalizes the axis, takes cosine and sine by CORDIC, and forms the
// Rodrigues matrix c*I + s*[n]x + (1-c)*n*n^T in signed Q1.14.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes one word per transform: angle (Q2.13 radians) and a
//   raw integer axis. rsp channel returns the nine matrix entries, row major,
//   each saturated to +-1.0, plus zero_axis (identity returned when the axis
//   is all zero).
//   The datapath is 73 register stages: 3 front stages, 32 square-root
//   stages (one root bit each), 32 divider stages plus a sign stage for the
//   axis normalization, and 5 matrix stages. The CORDIC runs beside the
//   square root and is delayed to meet the unit axis. Throughput is one
//   word per cycle unless rsp_stall holds a valid result; the whole
//   pipeline advances together. When rsp_stall holds a valid result,
//   every stage freezes and req_stall rises in the same cycle, so no word
//   is dropped or repeated; bubbles still move forward while the output
//   is empty or being taken.
//   Synchronous reset clears only the stage valid bits; the datapath needs
//   no reset and the block takes words in the first cycle after reset.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  aarm_pkg::req_type    req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output aarm_pkg::rsp_type    rsp_word
);
   import aarm_pkg::*;

   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic                  en;

   side_type              front_side;
   logic [SUM_W-1:0]      front_sum;
   logic signed [Z_W-1:0] front_z;
   logic                  front_neg;
   logic [ROOT_W-1:0]     root;
   side_type              root_side;
   nvec_type              unit_n;
   logic                  unit_zero;
   trig_type              trig;

   // advance whenever the output register is empty or being taken
   assign en        = !vld_ff[PIPE_DEPTH-1] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   // valid bits march with the data
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   aarm_front u_front (
      .clock    (clock),
      .en       (en),
      .req_word (req_word),
      .side     (front_side),
      .sum      (front_sum),
      .z        (front_z),
      .neg      (front_neg)
   );

   aarm_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .sum      (front_sum),
      .side_in  (front_side),
      .root     (root),
      .side_out (root_side)
   );

   aarm_divide u_divide (
      .clock   (clock),
      .en      (en),
      .root    (root),
      .side_in (root_side),
      .n       (unit_n),
      .zero    (unit_zero)
   );

   aarm_cordic u_cordic (
      .clock (clock),
      .en    (en),
      .z     (front_z),
      .neg   (front_neg),
      .cs    (trig)
   );

   aarm_matrix u_matrix (
      .clock    (clock),
      .en       (en),
      .n        (unit_n),
      .zero     (unit_zero),
      .cs       (trig),
      .rsp_word (rsp_word)
   );

endmodule

// ===== rtl/aarm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_front: input register, axis squares and angle range reduction
// Three stages: capture, square and wrap, sum and half-turn fold.
// ----------------------------------------------------------------------------
module aarm_front (
   input  logic                              clock,
   input  logic                              en,
   input  aarm_pkg::req_type                 req_word,
   output aarm_pkg::side_type                side,
   output logic [aarm_pkg::SUM_W-1:0]        sum,
   output logic signed [aarm_pkg::Z_W-1:0]   z,
   output logic                              neg
);
   import aarm_pkg::*;

   req_type                    in_ff;
   axis_type                   ax1;
   logic signed [2*FIELD_W-1:0] sq_full [3];
   logic [SQ_W-1:0]            sq_in [3];
   logic [SQ_W-1:0]            sq_ff [3];
   axis_type                   ax2_ff;
   logic signed [Z_W-1:0]      ang;
   logic signed [Z_W-1:0]      wrap_in, wrap_ff;
   logic [SUM_W-1:0]           sum_in, sum_ff;
   axis_type                   ax3_ff;
   logic                       zero_ff;
   logic signed [Z_W-1:0]      z_in, z_ff;
   logic                       neg_in, neg_ff;

   assign ax1 = {in_ff.axis_z, in_ff.axis_y, in_ff.axis_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_full[i] = $signed(ax1[i]) * $signed(ax1[i]);
         sq_in[i]   = sq_full[i][SQ_W-1:0];
      end
      ang = Z_W'(in_ff.angle) <<< ANG_SHIFT;
      if (ang > Z_PI) begin
         wrap_in = ang - Z_TWO_PI;
      end else if (ang < -Z_PI) begin
         wrap_in = ang + Z_TWO_PI;
      end else begin
         wrap_in = ang;
      end
   end

   always_comb begin
      sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      neg_in = 1'b0;
      z_in   = wrap_ff;
      if (wrap_ff > Z_HALF_PI) begin
         z_in   = wrap_ff - Z_PI;
         neg_in = 1'b1;
      end else if (wrap_ff < -Z_HALF_PI) begin
         z_in   = wrap_ff + Z_PI;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff   <= req_word;
         sq_ff   <= sq_in;
         ax2_ff  <= ax1;
         wrap_ff <= wrap_in;
         sum_ff  <= sum_in;
         zero_ff <= (sum_in == '0);
         ax3_ff  <= ax2_ff;
         z_ff    <= z_in;
         neg_ff  <= neg_in;
      end
   end

   assign side = '{axis: ax3_ff, zero: zero_ff};
   assign sum  = sum_ff;
   assign z    = z_ff;
   assign neg  = neg_ff;

endmodule

// ===== rtl/aarm_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_isqrt: pipelined integer square root of the squared axis length, scaled by 2^FRAC_Q
// One result bit per stage; the axis and zero flag ride along.
// ----------------------------------------------------------------------------
module aarm_isqrt (
   input  logic                             clock,
   input  logic                             en,
   input  logic [aarm_pkg::SUM_W-1:0]       sum,
   input  aarm_pkg::side_type               side_in,
   output logic [aarm_pkg::ROOT_W-1:0]      root,
   output aarm_pkg::side_type               side_out
);
   import aarm_pkg::*;

   logic [RAD_W-1:0] v_ff   [ISQRT_STAGES];
   logic [RAD_W-1:0] res_ff [ISQRT_STAGES];
   side_type         side_ff [ISQRT_STAGES];
   logic [RAD_W-1:0] v_src   [ISQRT_STAGES];
   logic [RAD_W-1:0] res_src [ISQRT_STAGES];
   side_type         side_src [ISQRT_STAGES];

   for (genvar k = 0; k < ISQRT_STAGES; k++) begin : g_stage
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
      logic [RAD_W-1:0] trial;
      logic             ge;
      logic [RAD_W-1:0] v_in, res_in;

      if (k == 0) begin : g_first
         assign v_src[k]    = RAD_W'(sum) << FRAC_Q;
         assign res_src[k]  = '0;
         assign side_src[k] = side_in;
      end else begin : g_next
         assign v_src[k]    = v_ff[k-1];
         assign res_src[k]  = res_ff[k-1];
         assign side_src[k] = side_ff[k-1];
      end

      always_comb begin
         trial  = res_src[k] + BIT;
         ge     = (v_src[k] >= trial);
         v_in   = ge ? (v_src[k] - trial) : v_src[k];
         res_in = ge ? ((res_src[k] >> 1) + BIT) : (res_src[k] >> 1);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k]    <= v_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign root     = res_ff[ISQRT_STAGES-1][ROOT_W-1:0];
   assign side_out = side_ff[ISQRT_STAGES-1];

endmodule

// ===== rtl/aarm_divide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_divide: three-lane pipelined divider scaling the axis to unit length
// Restoring division, one quotient bit per stage, then a sign stage.
// ----------------------------------------------------------------------------
module aarm_divide (
   input  logic                          clock,
   input  logic                          en,
   input  logic [aarm_pkg::ROOT_W-1:0]   root,
   input  aarm_pkg::side_type            side_in,
   output aarm_pkg::nvec_type            n,
   output logic                          zero
);
   import aarm_pkg::*;

   logic [REM_W-1:0]      rem_ff [DIV_STAGES][3];
   logic [DIV_STAGES-1:0] q_ff   [DIV_STAGES][3];
   logic [REM_W-1:0]      rem_src [DIV_STAGES][3];
   logic [DIV_STAGES-1:0] q_src   [DIV_STAGES][3];
   logic [ROOT_W-1:0]     root_ff [DIV_STAGES];
   logic [ROOT_W-1:0]     root_src [DIV_STAGES];
   logic [2:0]            sgn_ff  [DIV_STAGES];
   logic [2:0]            sgn_src [DIV_STAGES];
   logic                  zero_ff [DIV_STAGES];
   logic                  zero_src [DIV_STAGES];
   logic [FIELD_W:0]      mag [3];
   logic signed [FIELD_W:0] ext [3];
   nvec_type              n_in, n_ff;
   logic                  zero_out_ff;

   // dividend is |a| shifted up by NORM_SHIFT; its low bits are all zero,
   // so the top bits seed the remainder and zeros shift in
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         ext[l] = (FIELD_W + 1)'(side_in.axis[l]);
         mag[l] = ext[l][FIELD_W] ? (FIELD_W + 1)'(-ext[l]) : (FIELD_W + 1)'(ext[l]);
      end
   end

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      if (j == 0) begin : g_first
         assign root_src[j] = root;
         assign zero_src[j] = side_in.zero;
         for (genvar l = 0; l < 3; l++) begin : g_seed
            assign rem_src[j][l] = REM_W'(mag[l]) << DIV_PRESHIFT;
            assign q_src[j][l]   = '0;
            assign sgn_src[j][l] = side_in.axis[l][FIELD_W-1];
         end
      end else begin : g_next
         assign root_src[j] = root_ff[j-1];
         assign zero_src[j] = zero_ff[j-1];
         assign sgn_src[j]  = sgn_ff[j-1];
         for (genvar l = 0; l < 3; l++) begin : g_pass
            assign rem_src[j][l] = rem_ff[j-1][l];
            assign q_src[j][l]   = q_ff[j-1][l];
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [REM_W:0]   t;
         logic             ge;
         logic [REM_W-1:0] rem_in;
         logic [DIV_STAGES-1:0] q_in;

         always_comb begin
            t      = {rem_src[j][l], 1'b0};
            ge     = (t >= {1'b0, root_src[j]});
            rem_in = ge ? REM_W'(t - {1'b0, root_src[j]}) : REM_W'(t);
            q_in   = {q_src[j][l][DIV_STAGES-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j][l] <= rem_in;
               q_ff[j][l]   <= q_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[j] <= root_src[j];
            sgn_ff[j]  <= sgn_src[j];
            zero_ff[j] <= zero_src[j];
         end
      end
   end

   // truncate toward zero: divide magnitudes, then restore the sign
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         n_in[l] = sgn_ff[DIV_STAGES-1][l]
                 ? N_W'(-$signed({1'b0, q_ff[DIV_STAGES-1][l]}))
                 : N_W'($signed({1'b0, q_ff[DIV_STAGES-1][l]}));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff        <= n_in;
         zero_out_ff <= zero_ff[DIV_STAGES-1];
      end
   end

   assign n    = n_ff;
   assign zero = zero_out_ff;

endmodule

// ===== rtl/aarm_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_cordic: rotation-mode CORDIC for cosine and sine, plus alignment delay
// One micro-rotation per stage, then a delay line to meet the unit axis.
// ----------------------------------------------------------------------------
module aarm_cordic (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [aarm_pkg::Z_W-1:0]  z,
   input  logic                             neg,
   output aarm_pkg::trig_type               cs
);
   import aarm_pkg::*;

   logic signed [XY_W-1:0] x_ff [CORDIC_STAGES];
   logic signed [XY_W-1:0] y_ff [CORDIC_STAGES];
   logic signed [Z_W-1:0]  z_ff [CORDIC_STAGES];
   logic                   neg_ff [CORDIC_STAGES];
   logic signed [XY_W-1:0] x_src [CORDIC_STAGES];
   logic signed [XY_W-1:0] y_src [CORDIC_STAGES];
   logic signed [Z_W-1:0]  z_src [CORDIC_STAGES];
   logic                   neg_src [CORDIC_STAGES];
   trig_type               dly_ff [CORDIC_DELAY];
   trig_type               dly_in;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q30(5'(i)));
      logic signed [XY_W-1:0] sx, sy, x_in, y_in;
      logic signed [Z_W-1:0]  z_in;

      if (i == 0) begin : g_first
         assign x_src[i]   = XY_INV_GAIN;
         assign y_src[i]   = '0;
         assign z_src[i]   = z;
         assign neg_src[i] = neg;
      end else begin : g_next
         assign x_src[i]   = x_ff[i-1];
         assign y_src[i]   = y_ff[i-1];
         assign z_src[i]   = z_ff[i-1];
         assign neg_src[i] = neg_ff[i-1];
      end

      always_comb begin
         sx = x_src[i] >>> i;
         sy = y_src[i] >>> i;
         if (!z_src[i][Z_W-1]) begin
            x_in = x_src[i] - sy;
            y_in = y_src[i] + sx;
            z_in = z_src[i] - ATAN;
         end else begin
            x_in = x_src[i] + sy;
            y_in = y_src[i] - sx;
            z_in = z_src[i] + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            z_ff[i]   <= z_in;
            neg_ff[i] <= neg_src[i];
         end
      end
   end

   // undo the half-turn fold
   always_comb begin
      if (neg_ff[CORDIC_STAGES-1]) begin
         dly_in.c = CS_W'(-x_ff[CORDIC_STAGES-1]);
         dly_in.s = CS_W'(-y_ff[CORDIC_STAGES-1]);
      end else begin
         dly_in.c = CS_W'(x_ff[CORDIC_STAGES-1]);
         dly_in.s = CS_W'(y_ff[CORDIC_STAGES-1]);
      end
   end

   for (genvar d = 0; d < CORDIC_DELAY; d++) begin : g_dly
      if (d == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) begin
               dly_ff[d] <= dly_in;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) begin
               dly_ff[d] <= dly_ff[d-1];
            end
         end
      end
   end

   assign cs = dly_ff[CORDIC_DELAY-1];

endmodule

// ===== rtl/aarm_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_matrix: Rodrigues matrix assembly, rounding and saturation
// Five stages: products, outer-product rounding, scaling, sums, output word.
// ----------------------------------------------------------------------------
module aarm_matrix (
   input  logic                 clock,
   input  logic                 en,
   input  aarm_pkg::nvec_type   n,
   input  logic                 zero,
   input  aarm_pkg::trig_type   cs,
   output aarm_pkg::rsp_type    rsp_word
);
   import aarm_pkg::*;

   // outer-product pairs: xx, yy, zz, xy, xz, yz
   logic signed [P_W-1:0]    pnn_ff [6];
   logic signed [P_W-1:0]    psn1_ff [3];
   logic signed [CS_W-1:0]   c1_ff;
   logic                     z1_ff;
   logic signed [NN_W-1:0]   nn_ff [6];
   logic signed [NN_W-1:0]   omc_ff;
   logic signed [P_W-1:0]    psn2_ff [3];
   logic signed [CS_W-1:0]   c2_ff;
   logic                     z2_ff;
   logic signed [2*NN_W-1:0] pq_full [6];
   logic signed [P_W-1:0]    pq_ff [6];
   logic signed [P_W-1:0]    psn3_ff [3];
   logic signed [CS_W-1:0]   c3_ff;
   logic                     z3_ff;
   logic signed [P_W-1:0]    cq;
   logic signed [P_W-1:0]    e_in [9];
   logic signed [P_W-1:0]    e_ff [9];
   logic                     z4_ff;
   logic signed [P_W-1:0]    v [9];
   field_type                m_in [9];
   field_type                m_ff [9];
   logic                     zero_out_ff;

   for (genvar p = 0; p < 6; p++) begin : g_pair
      localparam int IA = (p < 3) ? p : ((p == 5) ? 1 : 0);
      localparam int IB = (p < 3) ? p : ((p == 3) ? 1 : 2);

      always_ff @(posedge clock) begin
         if (en) begin
            pnn_ff[p] <= $signed(n[IA]) * $signed(n[IB]);
         end
      end
   end

   always_comb begin
      for (int p = 0; p < 6; p++) begin
         pq_full[p] = omc_ff * nn_ff[p];
      end
      cq = P_W'(c3_ff) <<< FRAC_Q;
      e_in[0] = pq_ff[0] + cq;
      e_in[4] = pq_ff[1] + cq;
      e_in[8] = pq_ff[2] + cq;
      e_in[1] = pq_ff[3] - psn3_ff[2];
      e_in[2] = pq_ff[4] + psn3_ff[1];
      e_in[3] = pq_ff[3] + psn3_ff[2];
      e_in[5] = pq_ff[5] - psn3_ff[0];
      e_in[6] = pq_ff[4] - psn3_ff[1];
      e_in[7] = pq_ff[5] + psn3_ff[0];
      for (int k = 0; k < 9; k++) begin
         v[k] = (e_ff[k] + OUT_HALF) >>> OUT_SHIFT;
         if (z4_ff) begin
            m_in[k] = (k % 4 == 0) ? ONE_FIELD : '0;
         end else if (v[k] > OUT_LIM) begin
            m_in[k] = FIELD_W'(OUT_LIM);
         end else if (v[k] < -OUT_LIM) begin
            m_in[k] = FIELD_W'(-OUT_LIM);
         end else begin
            m_in[k] = FIELD_W'(v[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            psn1_ff[k] <= $signed(cs.s) * $signed(n[k]);
         end
         c1_ff <= cs.c;
         z1_ff <= zero;

         for (int p = 0; p < 6; p++) begin
            nn_ff[p] <= NN_W'((pnn_ff[p] + NN_HALF) >>> FRAC_Q);
         end
         omc_ff  <= NN_ONE - NN_W'(c1_ff);
         psn2_ff <= psn1_ff;
         c2_ff   <= c1_ff;
         z2_ff   <= z1_ff;

         for (int p = 0; p < 6; p++) begin
            pq_ff[p] <= pq_full[p][P_W-1:0];
         end
         psn3_ff <= psn2_ff;
         c3_ff   <= c2_ff;
         z3_ff   <= z2_ff;

         e_ff  <= e_in;
         z4_ff <= z3_ff;

         m_ff        <= m_in;
         zero_out_ff <= z4_ff;
      end
   end

   assign rsp_word = '{m00: m_ff[0], m01: m_ff[1], m02: m_ff[2],
                       m10: m_ff[3], m11: m_ff[4], m12: m_ff[5],
                       m20: m_ff[6], m21: m_ff[7], m22: m_ff[8],
                       zero_axis: zero_out_ff};

endmodule

// ===== rtl/aarm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_checker: port-level checks for the rotation matrix block
// Watches the handshakes and result words over time; bound to the top level.
// ----------------------------------------------------------------------------
module aarm_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_stall,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  aarm_pkg::rsp_type    rsp_word
);
   import aarm_pkg::*;

   field_type ent [9];
   logic      in_range;
   logic      is_identity;

   always_comb begin
      ent = '{rsp_word.m00, rsp_word.m01, rsp_word.m02,
              rsp_word.m10, rsp_word.m11, rsp_word.m12,
              rsp_word.m20, rsp_word.m21, rsp_word.m22};
      in_range = 1'b1;
      for (int k = 0; k < 9; k++) begin
         if ((P_W'(ent[k]) > OUT_LIM) || (P_W'(ent[k]) < -OUT_LIM)) begin
            in_range = 1'b0;
         end
      end
      is_identity = (ent[0] == ONE_FIELD) && (ent[4] == ONE_FIELD) && (ent[8] == ONE_FIELD)
                 && (ent[1] == '0) && (ent[2] == '0) && (ent[3] == '0)
                 && (ent[5] == '0) && (ent[6] == '0) && (ent[7] == '0);
   end

   // a held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // input backpressure only comes from a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("req stalled without a stalled result");

   // a zero axis always yields the identity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.zero_axis |-> is_identity)
      else $error("zero axis result is not identity");

   // entries never leave the saturation bounds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_range)
      else $error("matrix entry outside saturation bounds");

   // reset empties the pipeline
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression for axis_angle_rotation_matrix
// Drives directed and random angle/axis words through the req channel under
// several idling phases, predicts each matrix in exact integer arithmetic
// or takes the typed-in one, and compares each whole rsp word in arrival order.
// ----------------------------------------------------------------------------
module testbench;
   import aarm_pkg::*;

   localparam int N_RANDOM    = 1330;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 100;

   localparam longint Q_ONE      = 64'sd1073741824;
   localparam longint Q_PI       = 64'sd3373259426;
   localparam longint Q_HALF_PI  = 64'sd1686629713;
   localparam longint Q_TWO_PI   = 64'sd6746518852;
   localparam longint Q_INV_GAIN = 64'sd652032874;

   // idling phases
   typedef enum int {PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   rsp_type   matrix_queue[$];
   int        mismatch_count = 0;
   int        cycle_count = 0;
   phase_type phase = PH_NONE;

   axis_angle_rotation_matrix uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always #5 clock = ~clock;

   // directed rows; expected matrix typed in only for zero-axis rows
   typedef struct {
      req_type word;
      bit      fixed;
      rsp_type result;
   } row_type;

   function automatic longint div_floor(longint v, int k);
      longint m;
      if (v >= 0) return v >>> k;
      m = (64'sd1 << k) - 1;
      return -((-v + m) >>> k);
   endfunction

   function automatic longint div_round(longint v, int k);
      return div_floor(v + (64'sd1 << (k - 1)), k);
   endfunction

   function automatic longint root_floor(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint atan_entry(int idx);
      longint tbl[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
         33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
         131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
         32, 16, 8, 4, 2, 1, 0};
      return tbl[idx];
   endfunction

   function automatic rsp_type predict_matrix(req_type w);
      rsp_type       m;
      longint        a[3], n[3], sk[3][3];
      longint        z, x, y, xn, c, s, r, nn, e, v, lim;
      longint unsigned sum;
      bit            flip;
      field_type     vals[9];
      m = '0;
      lim = 64'sd1 << OUT_FRAC_BITS;
      a[0] = w.axis_x;
      a[1] = w.axis_y;
      a[2] = w.axis_z;
      sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      if (sum == 0) begin
         m.m00 = ONE_FIELD;
         m.m11 = ONE_FIELD;
         m.m22 = ONE_FIELD;
         m.zero_axis = 1'b1;
         return m;
      end
      r = root_floor(sum << 30);
      for (int i = 0; i < 3; i++) n[i] = (a[i] * (64'sd1 << 45)) / r;
      // fold the angle into the CORDIC's convergence range
      z = longint'(w.angle) * (64'sd1 << (30 - ANGLE_FRAC_BITS));
      z = z % Q_TWO_PI;
      if (z > Q_PI) z -= Q_TWO_PI;
      if (z < -Q_PI) z += Q_TWO_PI;
      flip = 0;
      if (z > Q_HALF_PI) begin
         z -= Q_PI;
         flip = 1;
      end else if (z < -Q_HALF_PI) begin
         z += Q_PI;
         flip = 1;
      end
      x = Q_INV_GAIN;
      y = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (z >= 0) begin
            xn = x - div_floor(y, i % 32);
            y = y + div_floor(x, i % 32);
            z -= atan_entry(i % 32);
         end else begin
            xn = x + div_floor(y, i % 32);
            y = y - div_floor(x, i % 32);
            z += atan_entry(i % 32);
         end
         x = xn;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
      sk[0] = '{0, -n[2], n[1]};
      sk[1] = '{n[2], 0, -n[0]};
      sk[2] = '{-n[1], n[0], 0};
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            nn = div_round(n[i] * n[j], 30);
            e = s * sk[i][j] + (Q_ONE - c) * nn;
            if (i == j) e += c * Q_ONE;
            v = div_round(e, 60 - OUT_FRAC_BITS);
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            vals[i * 3 + j] = field_type'(v);
         end
      m = {vals[0], vals[1], vals[2], vals[3], vals[4], vals[5],
           vals[6], vals[7], vals[8], 1'b0};
      return m;
   endfunction

   function automatic field_type pick_field();
      case ($urandom_range(0, 5))
         0:       return field_type'(16'sh7FFF);
         1:       return field_type'(16'sh8000);
         2:       return field_type'($urandom_range(0, 6)) - 16'sd3;
         default: return field_type'($urandom);
      endcase
   endfunction

   function automatic req_type random_word();
      req_type w;
      w.angle = field_type'($urandom_range(0, 51472)) - 16'sd25736;
      if ($urandom_range(0, 19) == 0) w.angle = field_type'($urandom);
      w.axis_x = pick_field();
      w.axis_y = pick_field();
      w.axis_z = pick_field();
      if ($urandom_range(0, 29) == 0) begin
         w.axis_x = '0;
         w.axis_y = '0;
         w.axis_z = '0;
      end
      return w;
   endfunction

   // idle or stall the sender according to the phase
   function automatic bit sender_idles();
      case (phase)
         PH_SEND_IDLE: return $urandom_range(0, 99) < 67;
         PH_BOTH:      return $urandom_range(0, 99) < 36;
         default:      return 1'b0;
      endcase
   endfunction

   // hold one word on the bus until it is taken
   task automatic send_word(req_type w, bit fixed, rsp_type result);
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      matrix_queue.push_back(fixed ? result : predict_matrix(w));
      @(negedge clock);
   endtask

   // receiver: randomize stall at each falling edge
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else case (phase)
         PH_RECV_STALL: rsp_stall <= ($urandom_range(0, 99) < 67);
         PH_BOTH:       rsp_stall <= ($urandom_range(0, 99) < 36);
         default:       rsp_stall <= 1'b0;
      endcase
   end

   // compare each accepted word with the oldest expected matrix
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (matrix_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected rsp word %h", rsp_word);
         end else begin
            rsp_type want;
            want = matrix_queue.pop_front();
            if (want !== rsp_word) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h actual %h", want, rsp_word);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      row_type   rows[$];
      rsp_type   ident;
      int        chunk;
      ident = '0;
      ident.m00 = ONE_FIELD;
      ident.m11 = ONE_FIELD;
      ident.m22 = ONE_FIELD;
      ident.zero_axis = 1'b1;

      // zero axis at zero and at the angle extremes, then axis and angle corners
      rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, ident});
      rows.push_back('{'{16'sd25736, 16'sd0, 16'sd0, 16'sd0}, 1, ident});
      rows.push_back('{'{-16'sd25736, 16'sd0, 16'sd0, 16'sd0}, 1, ident});
      rows.push_back('{'{16'sh8000, 16'sd0, 16'sd0, 16'sd0}, 1, ident});
      rows.push_back('{'{16'sd0, 16'sd1, 16'sd0, 16'sd0}, 0, ident});
      rows.push_back('{'{16'sd12868, 16'sd0, 16'sd1, 16'sd0}, 0, ident});
      rows.push_back('{'{-16'sd12868, 16'sd0, 16'sd0, 16'sd1}, 0, ident});
      rows.push_back('{'{16'sd25736, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 0, ident});
      rows.push_back('{'{-16'sd25736, 16'sh8000, 16'sh8000, 16'sh8000}, 0, ident});
      rows.push_back('{'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd1}, 0, ident});
      rows.push_back('{'{16'sh8000, -16'sd1, -16'sd1, -16'sd1}, 0, ident});
      rows.push_back('{'{16'sd12869, 16'sd3, -16'sd4, 16'sd0}, 0, ident});
      rows.push_back('{'{-16'sd12869, 16'sd0, 16'sh8000, 16'sd0}, 0, ident});
      rows.push_back('{'{16'sd6434, 16'sd0, 16'sd0, 16'sh7FFF}, 0, ident});
      rows.push_back('{'{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA}, 0, ident});
      rows.push_back('{'{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555}, 0, ident});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_word(rows[i].word, rows[i].fixed, rows[i].result);

      // random part, walked through every idling phase
      chunk = N_RANDOM / 4;
      for (int p = 0; p < 4; p++) begin
         phase = phase_type'(p);
         for (int k = 0; k < chunk; k++) begin
            send_word(random_word(), 0, ident);
            // hold off once until the pipeline drains completely
            if (p == 1 && k == chunk / 2) begin
               req_valid <= 1'b0;
               while (matrix_queue.size() != 0) @(negedge clock);
            end
         end
      end
      req_valid <= 1'b0;
      phase = PH_NONE;

      while (matrix_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (mismatch_count == 0 && matrix_queue.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== axis_angle_rotation_matrix.f =====
rtl/aarm_pkg.sv
rtl/aarm_front.sv
rtl/aarm_isqrt.sv
rtl/aarm_divide.sv
rtl/aarm_cordic.sv
rtl/aarm_matrix.sv
rtl/axis_angle_rotation_matrix.sv
rtl/aarm_checker.sv
test/testbench.sv
